// File: sv/mbfr_pkg.sv
// shared constants and types for the msb-first bit field reader
package mbfr_pkg;

  localparam int unsigned BufferBytes = 256;
  localparam int unsigned AddrW       = $clog2(BufferBytes);
  localparam int unsigned LenW        = $clog2(BufferBytes + 1);
  localparam int unsigned PosW        = LenW + 3;
  localparam int unsigned MaxBits     = 32;
  localparam int unsigned FetchBytes  = 5;
  localparam int unsigned AccW        = FetchBytes * 8;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_READ_U = 3'd1,
    OP_READ_S = 3'd2,
    OP_REWIND = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_ALIGN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic fetch;
    logic align;
    logic emit;
    logic busy;
  } ctrl_t;

endpackage

// File: sv/msb_first_bit_field_reader.sv
// msb-first bit field reader: byte buffer, running bit position, field extraction
// a read that fits walks through the fetch, drain, align and emit states before the result strobe;
// busy stays high in those states and the next command is taken in the strobe cycle.
// the field is gathered from five bytes read one per cycle from the buffer's read
// port, then aligned and sign-handled; a short read skips the fetch and goes to emit.
// load, rewind and clear complete at the accepting edge with no result and no busy.
// reset clears length, position and control; buffer contents are not reset.
module msb_first_bit_field_reader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op_i,
  input  logic [7:0]  load_byte_i,
  input  logic [5:0]  bit_count_i,
  output logic        result_valid_o,
  output logic [31:0] field_value_o,
  output logic        short_read_o
);
  import mbfr_pkg::*;

  localparam logic [2:0] LastByte = 3'(FetchBytes - 1);

  state_e state_q, state_d;
  ctrl_t  ctrl;

  logic [7:0]          mem [BufferBytes];
  logic [7:0]          rd_data_q;
  logic                rd_vld_q;
  logic [AddrW-1:0]    rd_addr;

  logic [LenW-1:0]     len_q;
  logic [PosW-1:0]     pos_q;
  logic [AddrW-1:0]    base_q;
  logic [2:0]          off_q;
  logic [5:0]          n_q;
  logic                signed_q;
  logic                short_q;
  logic [2:0]          cnt_q;
  logic [AccW-1:0]     acc_q;
  logic [31:0]         field_q;
  logic                sign_q;

  logic                res_valid_q;
  logic [31:0]         res_value_q;
  logic                res_short_q;

  logic                accept;
  logic [5:0]          n_clamp;
  logic [PosW:0]       end_sum;
  logic [PosW:0]       lim;
  logic                fits;
  logic                sign_fits;
  logic                sfits;
  logic                mem_we;

  logic [5:0]          sh;
  logic [AccW-1:0]     shifted;
  logic [5:0]          mag_w;
  logic [31:0]         mask;
  logic [5:0]          sign_idx;

  // decode of the incoming command against current length and position
  always_comb begin
    accept    = start && !ctrl.busy;
    n_clamp   = (bit_count_i > 6'(MaxBits)) ? 6'(MaxBits) : bit_count_i;
    end_sum   = {1'b0, pos_q} + (PosW+1)'(n_clamp);
    lim       = {1'b0, len_q, 3'b000};
    fits      = end_sum <= lim;
    sign_fits = {1'b0, pos_q} < lim;
    sfits     = (n_clamp != 6'd0) && fits;
    mem_we    = accept && (op_i == OP_LOAD) && (len_q < LenW'(BufferBytes));
    rd_addr   = base_q + AddrW'(cnt_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_READ_U: state_d = fits ? ST_FETCH : ST_EMIT;
            OP_READ_S: state_d = sfits ? ST_FETCH : ST_EMIT;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_FETCH: state_d = (cnt_q == LastByte) ? ST_DRAIN : ST_FETCH;
      ST_DRAIN: state_d = ST_ALIGN;
      ST_ALIGN: state_d = ST_EMIT;
      ST_EMIT:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_IDLE:  ctrl = '0;
      ST_FETCH: begin
        ctrl.fetch = 1'b1;
        ctrl.busy  = 1'b1;
      end
      ST_DRAIN: ctrl.busy = 1'b1;
      ST_ALIGN: begin
        ctrl.align = 1'b1;
        ctrl.busy  = 1'b1;
      end
      ST_EMIT: begin
        ctrl.emit = 1'b1;
        ctrl.busy = 1'b1;
      end
      default:  ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // byte buffer, one write port and one read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[len_q[AddrW-1:0]] <= load_byte_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  // length and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      pos_q <= '0;
    end else if (accept) begin
      case (op_i)
        OP_LOAD: begin
          if (mem_we) begin
            len_q <= len_q + LenW'(1);
          end
        end
        OP_READ_U: begin
          if (fits) begin
            pos_q <= end_sum[PosW-1:0];
          end
        end
        OP_READ_S: begin
          if (sfits) begin
            pos_q <= end_sum[PosW-1:0];
          end else if (sign_fits) begin
            // sign bit stays consumed even when the magnitude is short
            pos_q <= pos_q + PosW'(1);
          end
        end
        OP_REWIND: pos_q <= '0;
        OP_CLEAR: begin
          len_q <= '0;
          pos_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // command latch and fetch sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= ctrl.fetch;
      if (accept) begin
        cnt_q <= '0;
      end else if (ctrl.fetch) begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      base_q   <= pos_q[AddrW+2:3];
      off_q    <= pos_q[2:0];
      n_q      <= n_clamp;
      signed_q <= (op_i == OP_READ_S);
      short_q  <= (op_i == OP_READ_S) ? !sfits : !fits;
    end
    if (rd_vld_q) begin
      acc_q <= {acc_q[AccW-9:0], rd_data_q};
    end
  end

  // alignment: first fetched byte sits at the top of the accumulator
  always_comb begin
    sh       = 6'(AccW) - {3'b000, off_q} - n_q;
    shifted  = acc_q >> sh;
    mag_w    = n_q - {5'b00000, signed_q};
    mask     = 32'hFFFF_FFFF >> (6'(MaxBits) - mag_w);
    sign_idx = n_q - 6'd1;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.align) begin
      field_q <= shifted[31:0] & mask;
      sign_q  <= signed_q & shifted[sign_idx];
    end
    if (ctrl.emit) begin
      if (short_q) begin
        res_value_q <= '0;
      end else if (sign_q) begin
        res_value_q <= 32'd0 - field_q;
      end else begin
        res_value_q <= field_q;
      end
      res_short_q <= short_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctrl.emit;
    end
  end

  assign busy           = ctrl.busy;
  assign result_valid_o = res_valid_q;
  assign field_value_o  = res_value_q;
  assign short_read_o   = res_short_q;

  // a short transfer always carries a zero value
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && short_read_o |-> field_value_o == 32'd0)
    else $error("short read with nonzero value");

  // position never runs past the loaded bits
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} <= {1'b0, len_q, 3'b000})
    else $error("bit position beyond loaded length");

  // a strobe follows exactly one emit cycle
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_EMIT))
    else $error("result strobe without emit");

  // an accepted read makes the block busy
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == OP_READ_U || op_i == OP_READ_S) |=> busy)
    else $error("read accepted but block not busy");

  // fetch counter stays within the byte window
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.fetch |-> cnt_q <= LastByte)
    else $error("fetch counter out of range");

endmodule
